/* sv/tce_pkg.sv */
// Shared types, codes and constants of the touch calibration engine.
// Used by the controller, the datapath, the divider and the top level.
package tce_pkg;

  // fixed widths and scaling
  localparam int COORD_BITS   = 12;
  localparam int SAMPLE_LIMIT = 1000;
  localparam int FRAC_BITS    = 16;
  localparam int CNT_W        = 10;
  localparam int SUM_W        = 22;
  localparam int DET_W        = 27;
  localparam int QC_W         = FRAC_BITS + 3;
  localparam int NUM_W        = FRAC_BITS + 24;
  localparam int DEN_W        = 26;
  localparam int DCNT_W       = $clog2(NUM_W + 1);
  localparam int MUL_W        = 34;
  localparam int ACC_W        = 64;

  // configuration register indexes
  localparam logic [2:0] CFG_JITTER  = 3'd0;
  localparam logic [2:0] CFG_MINSAMP = 3'd1;
  localparam logic [2:0] CFG_MINHOLD = 3'd2;
  localparam logic [2:0] CFG_MAXERR  = 3'd3;
  localparam logic [2:0] CFG_MINDET  = 3'd4;
  localparam logic [2:0] CFG_SCREEN  = 3'd5;

  typedef enum logic [1:0] {
    ACT_MAP, ACT_START, ACT_SAMPLE, ACT_CANCEL
  } action_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_STARTED, EV_ACCEPTED, EV_REJECTED,
    EV_FIT_FAIL, EV_VAL_FAIL, EV_COMPLETE, EV_CANCELLED
  } event_t;

  // datapath operations
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_CMD, OP_REJCHK, OP_DIVX, OP_WAITX, OP_DIVY, OP_WAITY,
    OP_STOREPT, OP_DET0, OP_DET1, OP_DETCHK, OP_N0, OP_N1, OP_N2, OP_N3,
    OP_NDIV, OP_C0W, OP_C1W, OP_SQ0, OP_SQ1, OP_C2A, OP_C2B, OP_C2W,
    OP_FAILFIT, OP_MAPA, OP_MAPB, OP_ROUND, OP_IDENT, OP_VDIFF, OP_VSQ0,
    OP_VSQ1, OP_FAILVAL, OP_ADV, OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_CMD, S_REJ, S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_STORE,
    S_DET0, S_DET1, S_DETCHK, S_N0, S_N1, S_DIV0, S_WAIT0, S_N2, S_N3,
    S_DIV1, S_WAIT1, S_SQ0, S_SQ1, S_SQCHK, S_C2A, S_C2B, S_C2W,
    S_FAILFIT, S_MAP0, S_MAPA, S_MAPB, S_ROUND, S_VDIFF, S_VSQ0, S_VSQ1,
    S_VCHK, S_FAILVAL, S_ADV, S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic axis;
    logic vmode;
  } cmd_t;

  typedef struct packed {
    logic rel;
    logic rej;
    logic st2;
    logic st_ge3;
    logic div_done;
    logic det_bad;
    logic cbig;
    logic sq_bad;
    logic vbox_bad;
    logic vsq_bad;
    logic mvalid;
  } stat_t;

  // calibration target positions
  function automatic logic [8:0] tgt_x(input logic [2:0] idx);
    logic [8:0] v;
    case (idx)
      3'd0:    v = 9'd80;
      3'd1:    v = 9'd280;
      3'd2:    v = 9'd180;
      3'd3:    v = 9'd110;
      3'd4:    v = 9'd250;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] tgt_y(input logic [2:0] idx);
    logic [8:0] v;
    case (idx)
      3'd0:    v = 9'd115;
      3'd1:    v = 9'd115;
      3'd2:    v = 9'd275;
      3'd3:    v = 9'd220;
      3'd4:    v = 9'd220;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // target deltas used by the fit, per axis
  localparam int FIT_A0 = int'(tgt_x(3'd1)) - int'(tgt_x(3'd0));
  localparam int FIT_B0 = int'(tgt_x(3'd2)) - int'(tgt_x(3'd0));
  localparam int FIT_A1 = int'(tgt_y(3'd1)) - int'(tgt_y(3'd0));
  localparam int FIT_B1 = int'(tgt_y(3'd2)) - int'(tgt_y(3'd0));

endpackage

/* sv/tce_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tce_pkg for operand widths.
module tce_div import tce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    shifted;
  logic              ge;

  // trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(shifted - {1'b0, den_r}) : DEN_W'(shifted);
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* sv/tce_ctrl.sv */
// Sequencer of the calibration engine: walks one item through the datapath.
// Depends on tce_pkg for states, operations and the command/status structs.
module tce_ctrl import tce_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;
  logic   mode_r, mode_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath command
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.axis      = axis_r;
    cmd.vmode     = mode_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        cmd.op    = OP_CMD;
        state_nxt = stat.rel ? S_REJ : S_MAP0;
      end
      S_REJ: begin
        cmd.op    = OP_REJCHK;
        state_nxt = stat.rej ? S_MAP0 : S_DIVX;
      end
      S_DIVX: begin
        cmd.op    = OP_DIVX;
        state_nxt = S_WAITX;
      end
      S_WAITX: begin
        cmd.op = OP_WAITX;
        if (stat.div_done) state_nxt = S_DIVY;
      end
      S_DIVY: begin
        cmd.op    = OP_DIVY;
        state_nxt = S_WAITY;
      end
      S_WAITY: begin
        cmd.op = OP_WAITY;
        if (stat.div_done) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op   = OP_STOREPT;
        axis_nxt = 1'b0;
        if (stat.st2) begin
          state_nxt = S_DET0;
        end else if (stat.st_ge3) begin
          mode_nxt  = 1'b1;
          state_nxt = S_MAPA;
        end else begin
          state_nxt = S_ADV;
        end
      end
      // fit: determinant, then per axis two gains and the offset
      S_DET0: begin
        cmd.op    = OP_DET0;
        state_nxt = S_DET1;
      end
      S_DET1: begin
        cmd.op    = OP_DET1;
        state_nxt = S_DETCHK;
      end
      S_DETCHK: begin
        cmd.op    = OP_DETCHK;
        state_nxt = stat.det_bad ? S_FAILFIT : S_N0;
      end
      S_N0: begin
        cmd.op    = OP_N0;
        state_nxt = S_N1;
      end
      S_N1: begin
        cmd.op    = OP_N1;
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        cmd.op    = OP_NDIV;
        state_nxt = S_WAIT0;
      end
      S_WAIT0: begin
        cmd.op = OP_C0W;
        if (stat.div_done) state_nxt = stat.cbig ? S_FAILFIT : S_N2;
      end
      S_N2: begin
        cmd.op    = OP_N2;
        state_nxt = S_N3;
      end
      S_N3: begin
        cmd.op    = OP_N3;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        cmd.op    = OP_NDIV;
        state_nxt = S_WAIT1;
      end
      S_WAIT1: begin
        cmd.op = OP_C1W;
        if (stat.div_done) state_nxt = stat.cbig ? S_FAILFIT : S_SQ0;
      end
      S_SQ0: begin
        cmd.op    = OP_SQ0;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.op    = OP_SQ1;
        state_nxt = S_SQCHK;
      end
      S_SQCHK: begin
        state_nxt = stat.sq_bad ? S_FAILFIT : S_C2A;
      end
      S_C2A: begin
        cmd.op    = OP_C2A;
        state_nxt = S_C2B;
      end
      S_C2B: begin
        cmd.op    = OP_C2B;
        state_nxt = S_C2W;
      end
      S_C2W: begin
        cmd.op = OP_C2W;
        if (axis_r) begin
          state_nxt = S_ADV;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = S_N0;
        end
      end
      S_FAILFIT: begin
        cmd.op    = OP_FAILFIT;
        state_nxt = S_MAP0;
      end
      // mapping of a point (identity without a stored mapping), for the result or for validation
      S_MAP0: begin
        if (stat.mvalid) begin
          mode_nxt  = 1'b0;
          axis_nxt  = 1'b0;
          state_nxt = S_MAPA;
        end else begin
          cmd.op    = OP_IDENT;
          state_nxt = S_OUT;
        end
      end
      S_MAPA: begin
        cmd.op    = OP_MAPA;
        state_nxt = S_MAPB;
      end
      S_MAPB: begin
        cmd.op    = OP_MAPB;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.op = OP_ROUND;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_MAPA;
        end else begin
          state_nxt = mode_r ? S_VDIFF : S_OUT;
        end
      end
      S_VDIFF: begin
        cmd.op    = OP_VDIFF;
        state_nxt = S_VSQ0;
      end
      S_VSQ0: begin
        cmd.op    = OP_VSQ0;
        state_nxt = stat.vbox_bad ? S_FAILVAL : S_VSQ1;
      end
      S_VSQ1: begin
        cmd.op    = OP_VSQ1;
        state_nxt = S_VCHK;
      end
      S_VCHK: begin
        state_nxt = stat.vsq_bad ? S_FAILVAL : S_ADV;
      end
      S_FAILVAL: begin
        cmd.op    = OP_FAILVAL;
        state_nxt = S_MAP0;
      end
      S_ADV: begin
        cmd.op    = OP_ADV;
        state_nxt = S_MAP0;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

/* sv/tce_dp.sv */
// Datapath of the calibration engine: press state, fit, mapping and result.
// Depends on tce_pkg and instantiates the serial divider tce_div.
module tce_dp import tce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic [1:0]  in_action,
  input  logic        in_pressed,
  input  logic [11:0] in_raw_x,
  input  logic [11:0] in_raw_y,
  input  logic [31:0] in_now_ms,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [11:0] out_mapped_x,
  output logic [11:0] out_mapped_y,
  output logic        out_consumed,
  output logic [2:0]  out_event,
  output logic [2:0]  out_target,
  output logic        out_calibrated
);

  // configuration
  logic [7:0]  jitter_r;
  logic [9:0]  minsamp_r;
  logic [15:0] minhold_r;
  logic [7:0]  maxerr_r;
  logic [23:0] mindet_r;
  logic [11:0] screen_r;

  // latched item
  action_t               act_r;
  logic                  prs_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [31:0]           now_r;

  // calibration state
  logic                  active_r, fwd_r, unstable_r, mvalid_r;
  logic [2:0]            step_r;
  logic [CNT_W-1:0]      count_r;
  logic [SUM_W-1:0]      sumx_r, sumy_r;
  logic [COORD_BITS-1:0] firstx_r, firsty_r;
  logic [31:0]           start_r;
  logic [COORD_BITS-1:0] fp_r [6];
  logic signed [31:0]    cand_r [6];
  logic signed [31:0]    mapc_r [6];

  // work registers
  logic signed [ACC_W-1:0] acc_r;
  logic [COORD_BITS-1:0]   ax_r, ay_r;
  logic signed [DET_W-1:0] det_r;
  logic                    qneg_r;
  logic signed [QC_W-1:0]  c0_r, c1_r;
  logic signed [31:0]      px_r, py_r;
  logic signed [32:0]      dx_r, dy_r;
  event_t                  ev_r;
  logic                    cons_r;

  // result register
  logic [11:0] omx_r, omy_r;
  logic        ocons_r, ocal_r;
  logic [2:0]  oev_r, ostep_r;

  localparam logic signed [ACC_W-1:0] SQ_LO    = ACC_W'(1) << (2 * FRAC_BITS - 2);
  localparam logic signed [ACC_W-1:0] SQ_HI    = SQ_LO * 9;
  localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] I32_MAX  = ACC_W'(32'h7fffffff);
  localparam logic signed [ACC_W-1:0] I32_MIN  = -(ACC_W'(32'h7fffffff)) - 1;
  localparam logic [NUM_W-1:0]        GAIN_LIM = NUM_W'(2) << FRAC_BITS;

  // fit geometry
  logic signed [12:0] ux, uy, vx, vy;
  always_comb begin
    ux = $signed({1'b0, fp_r[2]}) - $signed({1'b0, fp_r[0]});
    uy = $signed({1'b0, fp_r[3]}) - $signed({1'b0, fp_r[1]});
    vx = $signed({1'b0, fp_r[4]}) - $signed({1'b0, fp_r[0]});
    vy = $signed({1'b0, fp_r[5]}) - $signed({1'b0, fp_r[1]});
  end

  // per-axis selections
  logic signed [MUL_W-1:0] ga, gb;
  logic [8:0]              t0;
  logic signed [31:0]      k0, k1, k2;
  logic [COORD_BITS-1:0]   xs, ys;
  always_comb begin
    ga = cmd.axis ? MUL_W'(FIT_A1) : MUL_W'(FIT_A0);
    gb = cmd.axis ? MUL_W'(FIT_B1) : MUL_W'(FIT_B0);
    t0 = cmd.axis ? tgt_y(3'd0) : tgt_x(3'd0);
    if (cmd.vmode) begin
      k0 = cmd.axis ? cand_r[3] : cand_r[0];
      k1 = cmd.axis ? cand_r[4] : cand_r[1];
      k2 = cmd.axis ? cand_r[5] : cand_r[2];
    end else begin
      k0 = cmd.axis ? mapc_r[3] : mapc_r[0];
      k1 = cmd.axis ? mapc_r[4] : mapc_r[1];
      k2 = cmd.axis ? mapc_r[5] : mapc_r[2];
    end
    xs = cmd.vmode ? ax_r : x_r;
    ys = cmd.vmode ? ay_r : y_r;
  end

  // shared multiplier and accumulator
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   pr, acc_nxt, acc_mag;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DET0: begin mul_a = MUL_W'(ux); mul_b = MUL_W'(vy); end
      OP_DET1: begin mul_a = MUL_W'(uy); mul_b = MUL_W'(vx); end
      OP_N0:   begin mul_a = ga; mul_b = MUL_W'(vy); end
      OP_N1:   begin mul_a = gb; mul_b = MUL_W'(uy); end
      OP_N2:   begin mul_a = MUL_W'(ux); mul_b = gb; end
      OP_N3:   begin mul_a = MUL_W'(vx); mul_b = ga; end
      OP_SQ0:  begin mul_a = MUL_W'(c0_r); mul_b = MUL_W'(c0_r); end
      OP_SQ1:  begin mul_a = MUL_W'(c1_r); mul_b = MUL_W'(c1_r); end
      OP_C2A: begin
        mul_a = MUL_W'(c0_r);
        mul_b = $signed({{(MUL_W-COORD_BITS){1'b0}}, fp_r[0]});
      end
      OP_C2B: begin
        mul_a = MUL_W'(c1_r);
        mul_b = $signed({{(MUL_W-COORD_BITS){1'b0}}, fp_r[1]});
      end
      OP_MAPA: begin mul_a = MUL_W'(k0); mul_b = $signed({{(MUL_W-COORD_BITS){1'b0}}, xs}); end
      OP_MAPB: begin mul_a = MUL_W'(k1); mul_b = $signed({{(MUL_W-COORD_BITS){1'b0}}, ys}); end
      OP_VSQ0: begin mul_a = MUL_W'(dx_r); mul_b = MUL_W'(dx_r); end
      OP_VSQ1: begin mul_a = MUL_W'(dy_r); mul_b = MUL_W'(dy_r); end
      default: ;
    endcase
    prod = mul_a * mul_b;
    pr   = prod[ACC_W-1:0];
    case (cmd.op)
      OP_DET0, OP_N0, OP_N2, OP_SQ0, OP_VSQ0: acc_nxt = pr;
      OP_DET1, OP_N1, OP_N3, OP_C2B:          acc_nxt = acc_r - pr;
      OP_SQ1, OP_MAPB, OP_VSQ1:               acc_nxt = acc_r + pr;
      OP_C2A:  acc_nxt = $signed(ACC_W'(t0) << FRAC_BITS) - pr;
      OP_MAPA: acc_nxt = pr + ACC_W'(k2);
      default: acc_nxt = acc_r;
    endcase
    acc_mag = acc_r[ACC_W-1] ? -acc_r : acc_r;
  end

  // divider operands
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  logic [DET_W-1:0]   det_mag;
  logic signed [QC_W-1:0] cval;
  always_comb begin
    det_mag   = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    div_start = 1'b0;
    div_num   = NUM_W'(sumx_r);
    div_den   = DEN_W'(count_r);
    case (cmd.op)
      OP_DIVX: div_start = 1'b1;
      OP_DIVY: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sumy_r);
      end
      OP_NDIV: begin
        div_start = 1'b1;
        div_num   = (NUM_W'(acc_mag[NUM_W-FRAC_BITS-1:0]) << FRAC_BITS)
                  + NUM_W'(det_mag[DEN_W-1:1]);
        div_den   = det_mag[DEN_W-1:0];
      end
      default: ;
    endcase
    cval = qneg_r ? -$signed(div_quot[QC_W-1:0]) : $signed(div_quot[QC_W-1:0]);
  end

  tce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // press sample update
  logic [COORD_BITS-1:0] fx, fy, ddx, ddy;
  logic [CNT_W-1:0]      cnt0;
  logic [SUM_W-1:0]      sx0, sy0;
  logic                  unst;
  always_comb begin
    fx   = fwd_r ? firstx_r : x_r;
    fy   = fwd_r ? firsty_r : y_r;
    ddx  = (x_r > fx) ? x_r - fx : fx - x_r;
    ddy  = (y_r > fy) ? y_r - fy : fy - y_r;
    unst = (fwd_r & unstable_r) | (ddx > COORD_BITS'(jitter_r))
         | (ddy > COORD_BITS'(jitter_r));
    cnt0 = fwd_r ? count_r : '0;
    sx0  = fwd_r ? sumx_r : '0;
    sy0  = fwd_r ? sumy_r : '0;
  end

  // rounding, saturation and checks
  logic signed [ACC_W-1:0] rnd, neg_acc;
  logic signed [31:0]      c2_sat;
  logic signed [32:0]      me_s;
  logic [15:0]             me_sq;
  always_comb begin
    neg_acc = -acc_r;
    rnd     = acc_r[ACC_W-1] ? -((neg_acc + HALF) >>> FRAC_BITS)
                             : ((acc_r + HALF) >>> FRAC_BITS);
    if (acc_r > I32_MAX)      c2_sat = 32'sh7fffffff;
    else if (acc_r < I32_MIN) c2_sat = -32'sh7fffffff - 32'sd1;
    else                      c2_sat = acc_r[31:0];
    me_s  = $signed({25'b0, maxerr_r});
    me_sq = maxerr_r * maxerr_r;
  end

  always_comb begin
    stat.rel      = (act_r == ACT_SAMPLE) && active_r && !prs_r && fwd_r;
    stat.rej      = (count_r == '0) || (count_r < minsamp_r)
                 || ((now_r - start_r) < 32'(minhold_r)) || unstable_r
                 || (step_r > 3'd4);
    stat.st2      = step_r == 3'd2;
    stat.st_ge3   = step_r >= 3'd3;
    stat.div_done = div_done;
    stat.det_bad  = (acc_r == '0) || (acc_mag < ACC_W'(mindet_r));
    stat.cbig     = div_quot > GAIN_LIM;
    stat.sq_bad   = (acc_r < SQ_LO) || (acc_r > SQ_HI);
    stat.vbox_bad = (dx_r > me_s) || (dx_r < -me_s) || (dy_r > me_s) || (dy_r < -me_s);
    stat.vsq_bad  = acc_r > $signed(ACC_W'(me_sq));
    stat.mvalid   = mvalid_r;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_r  <= 8'd15;
      minsamp_r <= 10'd3;
      minhold_r <= 16'd50;
      maxerr_r  <= 8'd18;
      mindet_r  <= 24'd1000;
      screen_r  <= 12'd359;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_JITTER:  jitter_r  <= cfg_wdata[7:0];
        CFG_MINSAMP: minsamp_r <= cfg_wdata[9:0];
        CFG_MINHOLD: minhold_r <= cfg_wdata[15:0];
        CFG_MAXERR:  maxerr_r  <= cfg_wdata[7:0];
        CFG_MINDET:  mindet_r  <= cfg_wdata[23:0];
        CFG_SCREEN:  screen_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // calibration control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      fwd_r      <= 1'b0;
      unstable_r <= 1'b0;
      mvalid_r   <= 1'b0;
      step_r     <= '0;
      count_r    <= '0;
      sumx_r     <= '0;
      sumy_r     <= '0;
      firstx_r   <= '0;
      firsty_r   <= '0;
      start_r    <= '0;
    end else begin
      case (cmd.op)
        OP_CMD: begin
          case (act_r)
            ACT_START: begin
              if (!active_r) begin
                active_r <= 1'b1;
                step_r   <= '0;
                count_r  <= '0;
                fwd_r    <= 1'b0;
              end
            end
            ACT_CANCEL: begin
              if (active_r) begin
                active_r <= 1'b0;
                fwd_r    <= 1'b0;
              end
            end
            ACT_SAMPLE: begin
              if (active_r) begin
                if (prs_r) begin
                  if (!fwd_r) begin
                    firstx_r <= x_r;
                    firsty_r <= y_r;
                    start_r  <= now_r;
                  end
                  unstable_r <= unst;
                  if (cnt0 < CNT_W'(SAMPLE_LIMIT)) begin
                    sumx_r  <= sx0 + SUM_W'(x_r);
                    sumy_r  <= sy0 + SUM_W'(y_r);
                    count_r <= cnt0 + 1'b1;
                  end else begin
                    sumx_r  <= sx0;
                    sumy_r  <= sy0;
                    count_r <= cnt0;
                  end
                  fwd_r <= 1'b1;
                end else if (fwd_r) begin
                  fwd_r <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        OP_FAILFIT, OP_FAILVAL: step_r <= '0;
        OP_ADV: begin
          step_r <= step_r + 1'b1;
          if (step_r == 3'd4) begin
            mvalid_r <= 1'b1;
            active_r <= 1'b0;
            fwd_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // event and consumed flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r   <= EV_NONE;
      cons_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          ev_r   <= EV_NONE;
          cons_r <= 1'b0;
        end
        OP_CMD: begin
          if (act_r == ACT_START && !active_r)        ev_r   <= EV_STARTED;
          else if (act_r == ACT_CANCEL && active_r)   ev_r   <= EV_CANCELLED;
          if (act_r == ACT_SAMPLE && active_r)        cons_r <= 1'b1;
        end
        OP_REJCHK:  if (stat.rej) ev_r <= EV_REJECTED;
        OP_FAILFIT: ev_r <= EV_FIT_FAIL;
        OP_FAILVAL: ev_r <= EV_VAL_FAIL;
        OP_ADV:     ev_r <= (step_r == 3'd4) ? EV_COMPLETE : EV_ACCEPTED;
        default: ;
      endcase
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    case (cmd.op)
      OP_LOAD: begin
        act_r <= action_t'(in_action);
        prs_r <= in_pressed;
        x_r   <= in_raw_x[COORD_BITS-1:0];
        y_r   <= in_raw_y[COORD_BITS-1:0];
        now_r <= in_now_ms;
      end
      OP_WAITX: if (div_done) ax_r <= div_quot[COORD_BITS-1:0];
      OP_WAITY: if (div_done) ay_r <= div_quot[COORD_BITS-1:0];
      OP_STOREPT: begin
        if (step_r < 3'd3) begin
          fp_r[{step_r[1:0], 1'b0}] <= ax_r;
          fp_r[{step_r[1:0], 1'b1}] <= ay_r;
        end
      end
      OP_DETCHK: det_r  <= acc_r[DET_W-1:0];
      OP_NDIV:   qneg_r <= acc_r[ACC_W-1] ^ det_r[DET_W-1];
      OP_C0W:    if (div_done) c0_r <= cval;
      OP_C1W:    if (div_done) c1_r <= cval;
      OP_C2W: begin
        if (cmd.axis) begin
          cand_r[3] <= 32'(c0_r);
          cand_r[4] <= 32'(c1_r);
          cand_r[5] <= c2_sat;
        end else begin
          cand_r[0] <= 32'(c0_r);
          cand_r[1] <= 32'(c1_r);
          cand_r[2] <= c2_sat;
        end
      end
      OP_ROUND: begin
        if (cmd.axis) py_r <= rnd[31:0];
        else          px_r <= rnd[31:0];
      end
      OP_IDENT: begin
        px_r <= $signed({{(32-COORD_BITS){1'b0}}, x_r});
        py_r <= $signed({{(32-COORD_BITS){1'b0}}, y_r});
      end
      OP_VDIFF: begin
        dx_r <= 33'(px_r) - $signed({24'b0, tgt_x(step_r)});
        dy_r <= 33'(py_r) - $signed({24'b0, tgt_y(step_r)});
      end
      OP_ADV: begin
        if (step_r == 3'd4) begin
          for (int i = 0; i < 6; i++) mapc_r[i] <= cand_r[i];
        end
      end
      default: ;
    endcase
  end

  // result register with clamping to the screen
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      if (px_r < 0)                                omx_r <= '0;
      else if (px_r > $signed({20'b0, screen_r}))  omx_r <= screen_r;
      else                                         omx_r <= px_r[11:0];
      if (py_r < 0)                                omy_r <= '0;
      else if (py_r > $signed({20'b0, screen_r}))  omy_r <= screen_r;
      else                                         omy_r <= py_r[11:0];
      ocons_r <= cons_r;
      oev_r   <= ev_r;
      ostep_r <= step_r;
      ocal_r  <= mvalid_r;
    end
  end

  assign out_mapped_x   = omx_r;
  assign out_mapped_y   = omy_r;
  assign out_consumed   = ocons_r;
  assign out_event      = oev_r;
  assign out_target     = ostep_r;
  assign out_calibrated = ocal_r;

endmodule

/* sv/touch_calibration_affine_engine.sv */
// Touch calibration engine top level: stream ports, sequencer and datapath.
// Depends on tce_pkg, tce_ctrl, tce_dp and tce_div.
//
// One item is worked at a time and gives exactly one result item. A release that
// passes the sample checks runs two sample-average divisions on the serial divider
// (one quotient bit per cycle), and the release that ends the third target adds four
// gain divisions on the same divider. A finished result waits in the output register
// while the next item is already taken in.
module touch_calibration_affine_engine import tce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pressed, raw_x, raw_y, now_ms, zero fill
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mapped_x, mapped_y, consumed, target_index,
                                  // calibrated, zero fill
  output logic [2:0]  out_tuser   // event_res
);

  cmd_t        cmd;
  stat_t       stat;
  logic [11:0] mx, my;
  logic        cons, cal;
  logic [2:0]  ev, tgt;

  tce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tce_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_tuser),
    .in_pressed     (in_tdata[0]),
    .in_raw_x       (in_tdata[12:1]),
    .in_raw_y       (in_tdata[24:13]),
    .in_now_ms      (in_tdata[56:25]),
    .cmd            (cmd),
    .stat           (stat),
    .out_mapped_x   (mx),
    .out_mapped_y   (my),
    .out_consumed   (cons),
    .out_event      (ev),
    .out_target     (tgt),
    .out_calibrated (cal)
  );

  // result packing
  assign out_tdata = {3'b000, cal, tgt, cons, my, mx};
  assign out_tuser = ev;

`ifndef NO_ASSERTIONS
  // the sequencer leaves idle right after taking an item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item taken while another is in work");

  // a result only appears at the end of an item's work
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised without an item in work");

  // a stored mapping is never dropped
  a_map_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(stat.mvalid))
    else $error("stored mapping lost");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the touch calibration affine engine.
// Depends on tce_pkg and touch_calibration_affine_engine; carries its own predictor.
`timescale 1ns / 100ps

module tb_top;
  import tce_pkg::*;

  typedef struct packed {
    logic [11:0] mx;
    logic [11:0] my;
    logic        cons;
    event_t      ev;
    logic [2:0]  tidx;
    logic        cal;
  } exp_t;

  typedef struct {
    action_t     act;
    bit          prs;
    int          x;
    int          y;
    int unsigned t;
    bit          chk;
    exp_t        want;
  } vec_t;

  localparam int TGX[5] = '{80, 280, 180, 110, 250};
  localparam int TGY[5] = '{115, 115, 275, 220, 220};

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // pressed, raw_x, raw_y, now_ms, zero fill
  logic [1:0]  in_tuser = '0;   // action
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;       // mapped_x, mapped_y, consumed, target_index, calibrated
  logic [2:0]  out_tuser;       // event_res

  touch_calibration_affine_engine uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // predictor configuration and state
  int unsigned c_jit, c_mins, c_hold, c_maxe, c_mdet, c_scr;
  bit          m_active, m_down, m_unst, m_valid;
  int unsigned m_step, m_cnt, m_sx, m_sy, m_t0, m_fx, m_fy;
  longint      m_fit[6];
  int          m_cand[6];
  int          m_map[6];

  exp_t        result_q[$];
  int          fails = 0;
  int          phase_items = 0;
  bit          use_typed = 0;
  exp_t        typed_val;
  int          burst_left = 0;
  int unsigned clk_ms;
  bit          hold_go = 0;
  int          hold_left = 0;
  int          pat_left = 0;
  int          ready_pct = 100;
  exp_t        got_r, want_r;

  function automatic longint round_q(longint v);
    longint half;
    half = longint'(1) << (FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> FRAC_BITS;
    return -((-v + half) >>> FRAC_BITS);
  endfunction

  function automatic longint div_near(longint n, longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic void map_point(input int c[6], input longint x, input longint y,
                                    output longint px, output longint py);
    px = round_q(longint'(c[0]) * x + longint'(c[1]) * y + longint'(c[2]));
    py = round_q(longint'(c[3]) * x + longint'(c[4]) * y + longint'(c[5]));
  endfunction

  function automatic logic [11:0] clamp_scr(longint v);
    if (v < 0) return 12'd0;
    if (v > longint'(c_scr)) return c_scr[11:0];
    return v[11:0];
  endfunction

  // three-point affine fit into the candidate coefficients
  function automatic bit fit_triangle();
    longint one, ux, uy, vx, vy, det, adet, a, b, c0, c1, c2, lim, lo, sq;
    longint res[6];
    one = longint'(1) << FRAC_BITS;
    ux = m_fit[2] - m_fit[0];
    uy = m_fit[3] - m_fit[1];
    vx = m_fit[4] - m_fit[0];
    vy = m_fit[5] - m_fit[1];
    det = ux * vy - uy * vx;
    adet = (det < 0) ? -det : det;
    if (adet == 0 || adet < longint'(c_mdet)) return 0;
    for (int ax = 0; ax < 2; ax++) begin
      a = ax ? TGY[1] - TGY[0] : TGX[1] - TGX[0];
      b = ax ? TGY[2] - TGY[0] : TGX[2] - TGX[0];
      c0 = div_near((a * vy - b * uy) * one, det);
      c1 = div_near((ux * b - vx * a) * one, det);
      lim = 2 * one;
      lo = longint'(1) << (2 * FRAC_BITS - 2);
      if (c0 > lim || c0 < -lim || c1 > lim || c1 < -lim) return 0;
      sq = c0 * c0 + c1 * c1;
      if (sq < lo || sq > 9 * lo) return 0;
      c2 = (ax ? TGY[0] : TGX[0]) * one - c0 * m_fit[0] - c1 * m_fit[1];
      if (c2 > 64'sd2147483647) c2 = 64'sd2147483647;
      if (c2 < -64'sd2147483648) c2 = -64'sd2147483648;
      res[ax * 3] = c0;
      res[ax * 3 + 1] = c1;
      res[ax * 3 + 2] = c2;
    end
    for (int i = 0; i < 6; i++) m_cand[i] = int'(res[i]);
    return 1;
  endfunction

  // end of a press: accept, reject, fit, validate or complete
  function automatic event_t settle_press(int unsigned now);
    int unsigned st, dur;
    longint ax, ay, px, py, dx, dy, me;
    st = m_step;
    dur = now - m_t0;
    if (m_cnt == 0 || m_cnt < c_mins || dur < c_hold || m_unst) return EV_REJECTED;
    if (st > 4) return EV_REJECTED;
    ax = longint'(m_sx / m_cnt);
    ay = longint'(m_sy / m_cnt);
    if (st < 3) begin
      m_fit[st * 2] = ax;
      m_fit[st * 2 + 1] = ay;
    end
    if (st == 2 && !fit_triangle()) begin
      m_step = 0;
      return EV_FIT_FAIL;
    end
    if (st >= 3) begin
      me = longint'(c_maxe);
      map_point(m_cand, ax, ay, px, py);
      dx = px - TGX[st];
      dy = py - TGY[st];
      if (dx > me || dx < -me || dy > me || dy < -me || dx * dx + dy * dy > me * me) begin
        m_step = 0;
        return EV_VAL_FAIL;
      end
    end
    m_step = st + 1;
    if (m_step == 5) begin
      for (int i = 0; i < 6; i++) m_map[i] = m_cand[i];
      m_valid = 1;
      m_active = 0;
      m_down = 0;
      return EV_COMPLETE;
    end
    return EV_ACCEPTED;
  endfunction

  // expected result of one accepted item
  function automatic exp_t predict_item(action_t a, bit p, int unsigned x, int unsigned y,
                                        int unsigned now);
    exp_t r;
    int unsigned dx, dy;
    longint mx, my;
    r.ev = EV_NONE;
    r.cons = 0;
    case (a)
      ACT_START: if (!m_active) begin
        m_active = 1;
        m_step = 0;
        m_cnt = 0;
        m_down = 0;
        r.ev = EV_STARTED;
      end
      ACT_CANCEL: if (m_active) begin
        m_active = 0;
        m_down = 0;
        r.ev = EV_CANCELLED;
      end
      ACT_SAMPLE: if (m_active) begin
        r.cons = 1;
        if (p) begin
          if (!m_down) begin
            m_cnt = 0;
            m_sx = 0;
            m_sy = 0;
            m_fx = x;
            m_fy = y;
            m_t0 = now;
            m_unst = 0;
          end
          dx = (x > m_fx) ? x - m_fx : m_fx - x;
          dy = (y > m_fy) ? y - m_fy : m_fy - y;
          if (dx > c_jit || dy > c_jit) m_unst = 1;
          if (m_cnt < SAMPLE_LIMIT) begin
            m_sx += x;
            m_sy += y;
            m_cnt++;
          end
          m_down = 1;
        end else if (m_down) begin
          m_down = 0;
          r.ev = settle_press(now);
        end
      end
      default: ;
    endcase
    if (m_valid) map_point(m_map, longint'(x), longint'(y), mx, my);
    else begin
      mx = x;
      my = y;
    end
    r.mx = clamp_scr(mx);
    r.my = clamp_scr(my);
    r.tidx = m_step[2:0];
    r.cal = m_valid;
    return r;
  endfunction

  // offer one item, wait for it to be taken, then maybe start a gap
  task automatic send_item(action_t a, bit p, int x, int y, int unsigned t);
    exp_t e;
    in_tvalid <= 1;
    in_tuser <= a;
    in_tdata <= {7'b0, t, y[11:0], x[11:0], p};
    do @(posedge clk); while (!in_tready);
    e = predict_item(a, p, x & 12'hFFF, y & 12'hFFF, t);
    result_q.push_back(use_typed ? typed_val : e);
    phase_items++;
    if (burst_left > 0) burst_left--;
    else begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // sender waits until every result is back and the block is idle
  task automatic drain();
    in_tvalid <= 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_config(int unsigned v[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_addr <= i[2:0];
      cfg_wdata <= v[i][23:0];
      @(posedge clk);
    end
    cfg_we <= 0;
    c_jit = v[CFG_JITTER] & 8'hFF;
    c_mins = v[CFG_MINSAMP] & 10'h3FF;
    c_hold = v[CFG_MINHOLD] & 16'hFFFF;
    c_maxe = v[CFG_MAXERR] & 8'hFF;
    c_mdet = v[CFG_MINDET] & 24'hFFFFFF;
    c_scr = v[CFG_SCREEN] & 12'hFFF;
  endtask

  function automatic int clip_coord(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // one calibration run: start, then presses aimed at the current target
  task automatic run_calibration(int budget);
    int kx, ky, ox, oy, tr, st, n, jn, bx, by, px, py, fx, fy, r;
    bit degen;
    int unsigned t0;
    send_item(ACT_START, 0, $urandom_range(0, 4095), $urandom_range(0, 4095), clk_ms);
    kx = $urandom_range(6, 14);
    ky = $urandom_range(6, 14);
    ox = $urandom_range(0, 1500);
    oy = $urandom_range(0, 1500);
    degen = ($urandom_range(0, 99) < 5);
    tr = 0;
    while (m_active && tr < 10 && phase_items < budget) begin
      st = (m_step > 4) ? 4 : m_step;
      bx = degen ? ox : ox + TGX[st] * kx / 8;
      by = degen ? oy : oy + TGY[st] * ky / 8;
      if (st >= 3 && $urandom_range(0, 9) == 0) bx += $urandom_range(20, 200);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(ACT_CANCEL, $urandom_range(0, 1), bx, by, clk_ms);
        break;
      end
      if (c_mins > 8) n = c_mins + $urandom_range(0, 5);
      else n = $urandom_range(c_mins, c_mins + 4);
      // too few samples, or a release with no press at all
      if (r < 8) n = (c_mins > 1) ? $urandom_range(0, c_mins - 1) : 0;
      jn = (c_jit < 6) ? c_jit / 2 : 3;
      t0 = clk_ms;
      fx = 0;
      fy = 0;
      for (int s = 0; s < n; s++) begin
        px = clip_coord(bx + $urandom_range(0, 2 * jn) - jn);
        py = clip_coord(by + $urandom_range(0, 2 * jn) - jn);
        if (s == 0) begin
          fx = px;
          fy = py;
        end
        // jittery press: one sample just past the limit
        if (r >= 8 && r < 13 && s == 1)
          px = (fx + c_jit + 1 > 4095) ? fx - c_jit - 1 : fx + c_jit + 1;
        send_item(ACT_SAMPLE, 1, px, py, clk_ms);
        clk_ms += $urandom_range(1, 30);
      end
      if (r >= 13 && r < 18 && c_hold > 0) clk_ms = t0 + $urandom_range(0, c_hold - 1);
      else clk_ms += c_hold + $urandom_range(0, 20);
      send_item(ACT_SAMPLE, 0, bx, by, clk_ms);
      clk_ms += $urandom_range(1, 30);
      tr++;
    end
  endtask

  // receiver: random ready pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
        pat_left = $urandom_range(20, 200);
      end
      pat_left--;
      out_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // result check against the oldest expected item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r.mx = out_tdata[11:0];
      got_r.my = out_tdata[23:12];
      got_r.cons = out_tdata[24];
      got_r.tidx = out_tdata[27:25];
      got_r.cal = out_tdata[28];
      got_r.ev = event_t'(out_tuser);
      if (result_q.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d c=%0d ev=%0d t=%0d cal=%0d", $time,
                 got_r.mx, got_r.my, got_r.cons, got_r.ev, got_r.tidx, got_r.cal);
        fails++;
      end else begin
        want_r = result_q.pop_front();
        if (got_r !== want_r) begin
          $display("%0t mismatch exp x=%0d y=%0d c=%0d ev=%0d t=%0d cal=%0d",
                   $time, want_r.mx, want_r.my, want_r.cons, want_r.ev, want_r.tidx,
                   want_r.cal);
          $display("%0t          got x=%0d y=%0d c=%0d ev=%0d t=%0d cal=%0d",
                   $time, got_r.mx, got_r.my, got_r.cons, got_r.ev, got_r.tidx, got_r.cal);
          fails++;
        end
      end
    end
  end

  // directed items at reset settings
  vec_t dir_tab[20] = '{
    '{ACT_MAP,    0, 0,    0,    32'd0,        1, '{12'd0,   12'd0,   1'b0, EV_NONE, 3'd0, 1'b0}},
    '{ACT_MAP,    0, 4095, 4095, 32'hFFFFFFFF, 1, '{12'd359, 12'd359, 1'b0, EV_NONE, 3'd0, 1'b0}},
    '{ACT_CANCEL, 1, 100,  200,  32'd5,        1, '{12'd100, 12'd200, 1'b0, EV_NONE, 3'd0, 1'b0}},
    '{ACT_SAMPLE, 1, 5,    6,    32'd7,        1, '{12'd5,   12'd6,   1'b0, EV_NONE, 3'd0, 1'b0}},
    '{ACT_START,  0, 10,   10,   32'd8,        1, '{12'd10,  12'd10,  1'b0, EV_STARTED, 3'd0, 1'b0}},
    '{ACT_START,  1, 20,   20,   32'd9,        1, '{12'd20,  12'd20,  1'b0, EV_NONE, 3'd0, 1'b0}},
    '{ACT_SAMPLE, 0, 30,   30,   32'd10,       1, '{12'd30,  12'd30,  1'b1, EV_NONE, 3'd0, 1'b0}},
    '{ACT_SAMPLE, 1, 100,  100,  32'd1000,     1, '{12'd100, 12'd100, 1'b1, EV_NONE, 3'd0, 1'b0}},
    '{ACT_SAMPLE, 0, 100,  100,  32'd2000,     1, '{12'd100, 12'd100, 1'b1, EV_REJECTED, 3'd0,
                                                    1'b0}},
    '{ACT_SAMPLE, 1, 80,   115,  32'hFFFFFFF0, 0, '0},
    '{ACT_SAMPLE, 1, 81,   116,  32'hFFFFFFF8, 0, '0},
    '{ACT_SAMPLE, 1, 79,   114,  32'hFFFFFFFF, 0, '0},
    '{ACT_SAMPLE, 0, 80,   115,  32'h40,       0, '0},
    '{ACT_SAMPLE, 1, 200,  200,  32'd100,      0, '0},
    '{ACT_SAMPLE, 1, 230,  200,  32'd110,      0, '0},
    '{ACT_SAMPLE, 1, 200,  200,  32'd120,      0, '0},
    '{ACT_SAMPLE, 0, 200,  200,  32'd400,      0, '0},
    '{ACT_CANCEL, 0, 0,    0,    32'd500,      1, '{12'd0,   12'd0,   1'b0, EV_CANCELLED, 3'd1,
                                                    1'b0}},
    '{ACT_MAP,    1, 4095, 0,    32'd600,      1, '{12'd359, 12'd0,   1'b0, EV_NONE, 3'd1, 1'b0}},
    '{ACT_SAMPLE, 1, 4095, 4095, 32'd700,      1, '{12'd359, 12'd359, 1'b0, EV_NONE, 3'd1, 1'b0}}
  };

  // main sequence
  initial begin
    int unsigned cv[6];
    int total, budget;
    c_jit = 15; c_mins = 3; c_hold = 50; c_maxe = 18; c_mdet = 1000; c_scr = 359;
    m_active = 0; m_down = 0; m_unst = 0; m_valid = 0;
    m_step = 0; m_cnt = 0; m_sx = 0; m_sy = 0; m_t0 = 0; m_fx = 0; m_fy = 0;
    for (int i = 0; i < 6; i++) begin
      m_fit[i] = 0;
      m_cand[i] = 0;
      m_map[i] = 0;
    end
    total = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      use_typed = dir_tab[i].chk;
      typed_val = dir_tab[i].want;
      send_item(dir_tab[i].act, dir_tab[i].prs, dir_tab[i].x, dir_tab[i].y, dir_tab[i].t);
    end
    use_typed = 0;

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      total += phase_items;
      phase_items = 0;
      case (ph)
        0: ;
        1: cv = '{0, 1, 0, 0, 0, 1};
        2: cv = '{255, 1000, 65535, 255, 16777215, 4095};
        default: cv = '{$urandom_range(3, 60), $urandom_range(1, 5), $urandom_range(0, 120),
                        $urandom_range(3, 40), $urandom_range(0, 4000),
                        $urandom_range(200, 4095)};
      endcase
      if (ph != 0) set_config(cv);
      clk_ms = (ph == 3) ? 32'hFFFFF000 : $urandom;
      budget = (ph == 2) ? 1100 : 170;
      while (phase_items < budget) begin
        if ((ph == 0 || ph == 3) && phase_items > 40 && phase_items < 50) hold_go = 1;
        if ($urandom_range(0, 99) < 80) run_calibration(budget);
        else
          repeat ($urandom_range(1, 6))
            send_item(action_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                      $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
      end
    end

    drain();
    if (result_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, result_q.size());
      fails++;
    end
    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
